// ----- rtl/core/fq_pkg.sv -----
// ----------------------------------------------------------------------------
// fq_pkg: shared definitions for the Q24.8 arithmetic unit
// Action codes, status codes, float operand classes and default widths.
// ----------------------------------------------------------------------------
package fq_pkg;

  // Width of an operand or result word.
  localparam int unsigned DATA_W = 32;
  // Width of the action field.
  localparam int unsigned ACT_W = 5;
  // Default number of fraction bits.
  localparam int unsigned FRACTION_BITS_DEF = 8;

  // Actions carried by an input word.
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD = 5'd0,
    ACT_SUB = 5'd1,
    ACT_MUL = 5'd2,
    ACT_DIV = 5'd3,
    ACT_EQ  = 5'd4,
    ACT_NE  = 5'd5,
    ACT_LE  = 5'd6,
    ACT_GE  = 5'd7,
    ACT_LT  = 5'd8,
    ACT_GT  = 5'd9,
    ACT_MIN = 5'd10,
    ACT_MAX = 5'd11,
    ACT_I2X = 5'd12,
    ACT_F2X = 5'd13,
    ACT_X2I = 5'd14,
    ACT_X2F = 5'd15,
    ACT_INC = 5'd16,
    ACT_DEC = 5'd17
  } action_e;

  // Status reported with each result.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  // Classes of a float operand after exponent decode.
  typedef enum logic [1:0] {
    FC_NORM = 2'd0,
    FC_ZERO = 2'd1,
    FC_OVER = 2'd2
  } fclass_e;

endpackage

// ----- rtl/core/fq_if.sv -----
// ----------------------------------------------------------------------------
// fq_in_if / fq_out_if: valid-ready channels of the arithmetic unit
// The input channel carries an action and two operands, the output channel
// carries the result, the comparison outcome and the status.
// ----------------------------------------------------------------------------
interface fq_in_if;
  logic                       valid;
  logic                       ready;
  logic [fq_pkg::ACT_W-1:0]   action;
  logic [fq_pkg::DATA_W-1:0]  operand_a;
  logic [fq_pkg::DATA_W-1:0]  operand_b;

  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface fq_out_if;
  logic                       valid;
  logic                       ready;
  logic [fq_pkg::DATA_W-1:0]  result;
  logic                       compare_true;
  logic [1:0]                 status;

  modport source (output valid, result, compare_true, status, input ready);
  modport sink   (input valid, result, compare_true, status, output ready);
endinterface

// ----- rtl/core/fq_div_step.sv -----
// ----------------------------------------------------------------------------
// fq_div_step: one restoring division step
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and appends one quotient bit.
// ----------------------------------------------------------------------------
module fq_div_step #(
  parameter int unsigned QW = 40
) (
  input  logic [32:0]    rem_i,
  input  logic [QW-1:0]  dvd_i,
  input  logic [QW-1:0]  quo_i,
  input  logic [31:0]    dsr_i,
  output logic [32:0]    rem_o,
  output logic [QW-1:0]  dvd_o,
  output logic [QW-1:0]  quo_o
);

  logic [32:0] sh;
  logic [33:0] diff;
  logic        fits;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    sh    = {rem_i[31:0], dvd_i[QW-1]};
    diff  = {1'b0, sh} - {2'b0, dsr_i};
    fits  = ~diff[33];
    rem_o = fits ? diff[32:0] : sh;
    dvd_o = {dvd_i[QW-2:0], 1'b0};
    quo_o = {quo_i[QW-2:0], fits};
  end

endmodule

// ----- rtl/core/fixed_point_q24_8_alu.sv -----
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu: pipelined signed Q24.8 arithmetic unit
// Add, subtract, multiply, divide, compare, min/max and format conversions.
// ----------------------------------------------------------------------------
// Usage:
//   in_i takes one word per valid/ready handshake: an action and two 32-bit
//   operands. out_o returns exactly one word per input word, in order: the
//   result pattern, the comparison outcome and a status code.
//   The pipeline has 37 + FRACTION_BITS stages: an input register, three
//   stages of front-end arithmetic (multiplier, float shifter, leading-one
//   search and rounding), one restoring division step per quotient bit
//   (32 + FRACTION_BITS steps) and a final sign and range stage.
//   Every action travels the same path, for Q24.8 as for any other
//   FRACTION_BITS. Throughput is one word per cycle while out_o does
//   not stall. Each stage holds its word while the stage after it cannot
//   load, so a stall on out_o fills the empty stages first and then
//   deasserts in_i.ready; nothing is lost or repeated.
//   Reset clears all valid bits; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu #(
  parameter int unsigned FRACTION_BITS = fq_pkg::FRACTION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fq_in_if.sink     in_i,
  fq_out_if.source  out_o
);

  import fq_pkg::*;

  localparam int unsigned QW   = 32 + FRACTION_BITS;
  localparam int unsigned NSTG = 5 + QW;
  localparam int unsigned DIV0 = 4;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [31:0]       a;
    logic [31:0]       b;
    logic [31:0]       res;
    logic              cmp;
    logic [1:0]        st;
    logic [63:0]       prod;
    logic              fneg;
    logic [1:0]        fcls;
    logic signed [9:0] fsh;
    logic [23:0]       fm;
    logic [31:0]       mag;
    logic [4:0]        lead;
    logic [QW-1:0]     dvd;
    logic [QW-1:0]     quo;
    logic [31:0]       dsr;
    logic [32:0]       rem;
    logic              dneg;
  } item_t;

  item_t             stg_q [NSTG];
  item_t             nxt   [NSTG];
  logic [NSTG-1:0]   vld_q;
  logic [NSTG-1:0]   en;

  // A stage may load when it is empty or its word moves on.
  always_comb begin
    en[NSTG-1] = ~vld_q[NSTG-1] | out_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  assign in_i.ready = en[0];

  // Valid bits travel with the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Word registers of every stage.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSTG; k++) begin
      if (en[k]) begin
        stg_q[k] <= nxt[k];
      end
    end
  end

  // Input stage captures the word.
  always_comb begin
    nxt[0]     = '0;
    nxt[0].act = in_i.action;
    nxt[0].a   = in_i.operand_a;
    nxt[0].b   = in_i.operand_b;
  end

  // Front stage: add/subtract, compare, min/max, shift conversions, multiplier and operand prep.
  always_comb begin
    item_t       i;
    item_t       o;
    logic [32:0] s_add, s_sub, s_inc, s_dec;
    logic [FRACTION_BITS:0] top;
    logic        gt, lt, eq;
    logic [31:0] abs_a, abs_b;
    i = stg_q[0];
    o = i;
    s_add = {i.a[31], i.a} + {i.b[31], i.b};
    s_sub = {i.a[31], i.a} - {i.b[31], i.b};
    s_inc = {i.a[31], i.a} + 33'd1;
    s_dec = {i.a[31], i.a} - 33'd1;
    top   = i.a[31 -: FRACTION_BITS + 1];
    gt    = $signed(i.a) > $signed(i.b);
    lt    = $signed(i.a) < $signed(i.b);
    eq    = i.a == i.b;
    abs_a = i.a[31] ? (32'd0 - i.a) : i.a;
    abs_b = i.b[31] ? (32'd0 - i.b) : i.b;
    o.res  = '0;
    o.cmp  = 1'b0;
    o.st   = ST_OK;
    o.prod = 64'($signed(i.a) * $signed(i.b));
    o.fneg = i.a[31];
    o.fm   = {1'b1, i.a[22:0]};
    o.fsh  = $signed({2'b0, i.a[30:23]} + 10'(FRACTION_BITS) - 10'd150);
    o.mag  = abs_a;
    o.dvd  = {abs_a, {FRACTION_BITS{1'b0}}};
    o.dsr  = abs_b;
    o.quo  = '0;
    o.rem  = '0;
    o.dneg = i.a[31] ^ i.b[31];
    if (i.a[30:23] == 8'hFF) begin
      o.fcls = FC_OVER;
    end else if (i.a[30:23] == 8'h00) begin
      o.fcls = FC_ZERO;
    end else if (o.fsh > 10'sd9) begin
      o.fcls = FC_OVER;
    end else begin
      o.fcls = FC_NORM;
    end
    case (action_e'(i.act))
      ACT_ADD: begin
        o.res = s_add[31:0];
        o.st  = (s_add[32] != s_add[31]) ? ST_OVF : ST_OK;
      end
      ACT_SUB: begin
        o.res = s_sub[31:0];
        o.st  = (s_sub[32] != s_sub[31]) ? ST_OVF : ST_OK;
      end
      ACT_INC: begin
        o.res = s_inc[31:0];
        o.st  = (s_inc[32] != s_inc[31]) ? ST_OVF : ST_OK;
      end
      ACT_DEC: begin
        o.res = s_dec[31:0];
        o.st  = (s_dec[32] != s_dec[31]) ? ST_OVF : ST_OK;
      end
      ACT_DIV: o.st  = (i.b == '0) ? ST_DIV0 : ST_OK;
      ACT_EQ:  o.cmp = eq;
      ACT_NE:  o.cmp = ~eq;
      ACT_LE:  o.cmp = ~gt;
      ACT_GE:  o.cmp = ~lt;
      ACT_LT:  o.cmp = lt;
      ACT_GT:  o.cmp = gt;
      ACT_MIN: o.res = gt ? i.b : i.a;
      ACT_MAX: o.res = gt ? i.a : i.b;
      ACT_I2X: begin
        o.res = i.a << FRACTION_BITS;
        o.st  = ((&top) || (~|top)) ? ST_OK : ST_OVF;
      end
      ACT_X2I: begin
        o.res = 32'($signed(i.a + (i.a[31] ? ((32'd1 << FRACTION_BITS) - 32'd1) : 32'd0))
                    >>> FRACTION_BITS);
      end
      default: ;
    endcase
    nxt[1] = o;
  end

  // Second stage: product scaling, float to fixed shift, leading-one search.
  always_comb begin
    item_t       i;
    item_t       o;
    logic [63:0] pb;
    logic [63:0] q;
    logic [33:0] mag;
    logic [33:0] lim;
    logic [9:0]  rr;
    logic [23:0] t;
    i = stg_q[1];
    o = i;
    pb  = i.prod + (i.prod[63] ? ((64'd1 << FRACTION_BITS) - 64'd1) : 64'd0);
    q   = 64'($signed(pb) >>> FRACTION_BITS);
    rr  = 10'd0 - i.fsh;
    t   = '0;
    mag = '0;
    lim = {2'b0, i.fneg ? 32'h8000_0000 : 32'h7FFF_FFFF};
    o.lead = '0;
    for (int k = 0; k < 32; k++) begin
      if (i.mag[k]) begin
        o.lead = 5'(k);
      end
    end
    if (!i.fsh[9]) begin
      mag = 34'(i.fm) << i.fsh[3:0];
    end else if (rr <= 10'd25) begin
      t   = i.fm >> (rr - 10'd1);
      mag = 34'((25'(t) + 25'd1) >> 1);
    end
    case (action_e'(i.act))
      ACT_MUL: begin
        o.res = q[31:0];
        o.st  = ((&q[63:31]) || (~|q[63:31])) ? ST_OK : ST_OVF;
      end
      ACT_F2X: begin
        if (i.fcls == FC_OVER || (i.fcls == FC_NORM && mag > lim)) begin
          o.res = i.fneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
          o.st  = ST_OVF;
        end else if (i.fcls == FC_ZERO) begin
          o.res = '0;
        end else begin
          o.res = i.fneg ? (32'd0 - mag[31:0]) : mag[31:0];
        end
      end
      default: ;
    endcase
    nxt[2] = o;
  end

  // Third stage: normalise and round the fixed to float conversion.
  always_comb begin
    item_t       i;
    item_t       o;
    logic [31:0] nrm;
    logic        up;
    logic [24:0] sig;
    logic [7:0]  ex;
    i = stg_q[2];
    o = i;
    nrm = i.mag << (5'd31 - i.lead);
    up  = nrm[7] & (nrm[8] | (|nrm[6:0]));
    sig = {1'b0, nrm[31:8]} + 25'(up);
    ex  = 8'({3'b0, i.lead} + 8'(sig[24]) + 8'd127 - 8'(FRACTION_BITS));
    if (action_e'(i.act) == ACT_X2F) begin
      if (i.mag == '0) begin
        o.res = '0;
      end else begin
        o.res = {i.fneg, ex, sig[24] ? 23'd0 : sig[22:0]};
      end
    end
    nxt[3] = o;
  end

  // Division steps, one quotient bit per stage.
  for (genvar g = 0; g < QW; g++) begin : g_div
    item_t       di;
    logic [32:0] rem_n;
    logic [QW-1:0] dvd_n, quo_n;

    assign di = stg_q[DIV0 - 1 + g];

    fq_div_step #(
      .QW (QW)
    ) u_step (
      .rem_i (di.rem),
      .dvd_i (di.dvd),
      .quo_i (di.quo),
      .dsr_i (di.dsr),
      .rem_o (rem_n),
      .dvd_o (dvd_n),
      .quo_o (quo_n)
    );

    always_comb begin
      nxt[DIV0 + g]     = di;
      nxt[DIV0 + g].rem = rem_n;
      nxt[DIV0 + g].dvd = dvd_n;
      nxt[DIV0 + g].quo = quo_n;
    end
  end

  // Final stage: sign and range of the quotient.
  always_comb begin
    item_t         i;
    item_t         o;
    logic [QW-1:0] val;
    logic          ovf;
    i = stg_q[NSTG-2];
    o = i;
    val = i.dneg ? ({QW{1'b0}} - i.quo) : i.quo;
    ovf = i.dneg ? (i.quo > {{(QW-32){1'b0}}, 32'h8000_0000})
                 : (i.quo > {{(QW-32){1'b0}}, 32'h7FFF_FFFF});
    if (action_e'(i.act) == ACT_DIV && i.dsr != '0) begin
      o.res = val[31:0];
      o.st  = ovf ? ST_OVF : ST_OK;
    end
    nxt[NSTG-1] = o;
  end

  // Output word.
  assign out_o.valid        = vld_q[NSTG-1];
  assign out_o.result       = stg_q[NSTG-1].res;
  assign out_o.compare_true = stg_q[NSTG-1].cmp;
  assign out_o.status       = stg_q[NSTG-1].st;

endmodule

// ----- rtl/core/fq_chk.sv -----
// ----------------------------------------------------------------------------
// fq_chk: port checks for the arithmetic unit
// Watches the output channel of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module fq_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] result_i,
  input  logic        compare_true_i,
  input  logic [1:0]  status_i
);

  import fq_pkg::*;

  // A stalled result word holds until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_i) && $stable(status_i))
    else $error("output word changed while stalled");

  // A true comparison carries a zero result and a clean status.
  a_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && compare_true_i |-> result_i == '0 && status_i == ST_OK)
    else $error("comparison word carries a result or status");

  // Division by zero gives a zero result.
  a_div0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_DIV0 |-> result_i == '0 && !compare_true_i)
    else $error("division by zero with nonzero result");

  // Only the three defined status codes appear.
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i == ST_OK || status_i == ST_OVF || status_i == ST_DIV0)
    else $error("undefined status code");

endmodule

bind fixed_point_q24_8_alu fq_chk u_fq_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_i       (out_o.result),
  .compare_true_i (out_o.compare_true),
  .status_i       (out_o.status)
);
